/* sv/sbps_pkg.sv */
// sbps_pkg: widths, types and codes shared by the segment break point snap block
// no dependencies; imported by sbps_div, segment_break_point_snap and its testbench

package sbps_pkg;

  // coordinate width used inside the block (ports stay at field width)
  localparam int COORD_BITS = 32;
  localparam int FIELD_BITS = 32;

  // derived widths of the exact rational arithmetic
  localparam int DIFF_BITS = COORD_BITS + 1;          // coordinate difference
  localparam int PROD_BITS = 2 * DIFF_BITS;           // product of two differences
  localparam int WIDE_BITS = PROD_BITS + 1;           // cross product sums
  localparam int MUL_BITS  = DIFF_BITS + WIDE_BITS;   // direction times cross product
  localparam int LO_BITS   = DIFF_BITS;               // low slice of a split multiply
  localparam int HI_BITS   = WIDE_BITS - LO_BITS;     // high slice of a split multiply
  localparam int QUO_BITS  = COORD_BITS + 2;          // quotient bits before saturation
  localparam int RES_BITS  = QUO_BITS + 2;            // rounded unsaturated coordinate
  localparam int TWO_BITS  = MUL_BITS + 1;            // doubled remainder
  localparam int DIV_LAT   = QUO_BITS + 4;            // divider latency in cycles

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [MUL_BITS-1:0]   mul_t;
  typedef logic signed [RES_BITS-1:0]   res_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = ~COORD_MAX;
  localparam res_t   RES_MAX   = RES_BITS'(COORD_MAX);
  localparam res_t   RES_MIN   = RES_BITS'(COORD_MIN);

  typedef enum logic [1:0] {
    OUT_DIRECT   = 2'd0,
    OUT_FALLBACK = 2'd1,
    OUT_KEPT     = 2'd2
  } outcome_e;

  // one coordinate to divide: b + m / d, m optionally negated
  typedef struct packed {
    mul_t   m;
    logic   neg;
    wide_t  d;
    coord_t b;
  } lane_t;

  // rounded coordinate; ovf means far out of range with sign sgn
  typedef struct packed {
    logic ovf;
    logic sgn;
    res_t val;
  } div_res_t;

  // per item context that travels beside the arithmetic
  typedef struct packed {
    logic   ux0;
    logic   uy0;
    logic   dx0;
    logic   none1;
    logic   none2;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t px;
    coord_t py;
    coord_t lo;
    coord_t hi;
  } ctx_t;

endpackage

/* sv/sbps_div.sv */
// sbps_div: pipelined restoring divider with round half away from zero
// computes b + m / d with overflow detection; uses sbps_pkg

module sbps_div (
  input  logic              clk_i,
  input  logic              en_i,
  input  sbps_pkg::lane_t   lane_i,
  output sbps_pkg::div_res_t res_o
);
  import sbps_pkg::*;

  // magnitudes and sign of the quotient
  logic [MUL_BITS-1:0]  mm_q;
  logic [WIDE_BITS-1:0] md_q;
  logic                 sg_q;
  coord_t               b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm_q <= lane_i.m[MUL_BITS-1] ? MUL_BITS'(-lane_i.m) : MUL_BITS'(lane_i.m);
      md_q <= lane_i.d[WIDE_BITS-1] ? WIDE_BITS'(-lane_i.d) : WIDE_BITS'(lane_i.d);
      sg_q <= lane_i.m[MUL_BITS-1] ^ lane_i.d[WIDE_BITS-1] ^ lane_i.neg;
      b_q  <= lane_i.b;
    end
  end

  // one quotient bit per stage
  logic [MUL_BITS-1:0]  rem_q [QUO_BITS+1];
  logic [QUO_BITS-1:0]  quo_q [QUO_BITS+1];
  logic [WIDE_BITS-1:0] dvs_q [QUO_BITS+1];
  logic                 sgs_q [QUO_BITS+1];
  logic                 ovs_q [QUO_BITS+1];
  coord_t               bs_q  [QUO_BITS+1];

  // overflow when the quotient would not fit the kept bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mm_q;
      quo_q[0] <= '0;
      dvs_q[0] <= md_q;
      sgs_q[0] <= sg_q;
      ovs_q[0] <= (mm_q >> QUO_BITS) >= MUL_BITS'(md_q);
      bs_q[0]  <= b_q;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int Sh = QUO_BITS - 1 - k;
    logic [MUL_BITS:0] trial;

    assign trial = {1'b0, rem_q[k]} - {1'b0, MUL_BITS'(dvs_q[k]) << Sh};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= trial[MUL_BITS] ? rem_q[k] : trial[MUL_BITS-1:0];
        quo_q[k+1] <= quo_q[k] | ({{(QUO_BITS-1){1'b0}}, !trial[MUL_BITS]} << Sh);
        dvs_q[k+1] <= dvs_q[k];
        sgs_q[k+1] <= sgs_q[k];
        ovs_q[k+1] <= ovs_q[k];
        bs_q[k+1]  <= bs_q[k];
      end
    end
  end

  // signed quotient and remainder versus half divisor
  res_t   sq_q;
  logic   gt_q;
  logic   eq_q;
  logic   sgc_q;
  logic   ovc_q;
  coord_t bc_q;
  logic [TWO_BITS-1:0] two_rem;
  logic [TWO_BITS-1:0] dvs_ext;

  assign two_rem = {rem_q[QUO_BITS], 1'b0};
  assign dvs_ext = TWO_BITS'(dvs_q[QUO_BITS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sgs_q[QUO_BITS] ? -RES_BITS'(quo_q[QUO_BITS]) : RES_BITS'(quo_q[QUO_BITS]);
      gt_q  <= two_rem > dvs_ext;
      eq_q  <= two_rem == dvs_ext;
      sgc_q <= sgs_q[QUO_BITS];
      ovc_q <= ovs_q[QUO_BITS];
      bc_q  <= bs_q[QUO_BITS];
    end
  end

  // add the base and round, ties away from zero
  res_t     base;
  res_t     up;
  res_t     dn;
  div_res_t res_d;
  div_res_t res_q;

  always_comb begin
    base = RES_BITS'(bc_q) + sq_q;
    up   = RES_BITS'(bc_q) + sq_q + RES_BITS'(1);
    dn   = RES_BITS'(bc_q) + sq_q - RES_BITS'(1);
    res_d.ovf = ovc_q;
    res_d.sgn = sgc_q;
    priority if (gt_q) begin
      res_d.val = sgc_q ? dn : up;
    end else if (eq_q) begin
      if (!sgc_q) begin
        res_d.val = base[RES_BITS-1] ? base : up;
      end else begin
        res_d.val = (!base[RES_BITS-1] && base != '0) ? base : dn;
      end
    end else begin
      res_d.val = base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* sv/segment_break_point_snap.sv */
// segment_break_point_snap: top level, joint point of a new segment on an existing one
// uses sbps_pkg and four sbps_div lanes

// The block takes one segment pair per cycle while the pipeline advances and returns one
// result per pair, in order, after six arithmetic stages, the divider and one output
// register; the latency comes from the 34 step restoring divider, one quotient bit a
// stage. The whole pipeline advances whenever the output register is empty or being
// taken, so a stall on the result side holds every stage in place. Both the direct
// intersection and the perpendicular fallback are computed for every pair, and the
// outcome code tells which one supplied the joint point.

module segment_break_point_snap (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] new_start_x_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] new_start_y_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] new_end_x_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] new_end_y_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] old_start_x_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] old_start_y_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] old_end_x_i,
  input  logic signed [sbps_pkg::FIELD_BITS-1:0] old_end_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sbps_pkg::FIELD_BITS-1:0] joint_x_o,
  output logic signed [sbps_pkg::FIELD_BITS-1:0] joint_y_o,
  output logic signed [sbps_pkg::FIELD_BITS-1:0] moved_end_x_o,
  output logic signed [sbps_pkg::FIELD_BITS-1:0] moved_end_y_o,
  output sbps_pkg::outcome_e                   outcome_o
);
  import sbps_pkg::*;

  localparam int NSTG = 7 + DIV_LAT;

  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv        = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  // valid bits travel with the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 1: capture, low coordinate bits
  coord_t nsx_q, nsy_q, nex_q, ney_q, osx_q, osy_q, oex_q, oey_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nsx_q <= new_start_x_i[COORD_BITS-1:0];
      nsy_q <= new_start_y_i[COORD_BITS-1:0];
      nex_q <= new_end_x_i[COORD_BITS-1:0];
      ney_q <= new_end_y_i[COORD_BITS-1:0];
      osx_q <= old_start_x_i[COORD_BITS-1:0];
      osy_q <= old_start_y_i[COORD_BITS-1:0];
      oex_q <= old_end_x_i[COORD_BITS-1:0];
      oey_q <= old_end_y_i[COORD_BITS-1:0];
    end
  end

  // stage 2: directions, offsets, span and shape flags
  ctx_t  ctx2_q;
  diff_t ux2_q, uy2_q, dx2_q, dy2_q, ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux2_q        <= DIFF_BITS'(nex_q) - DIFF_BITS'(nsx_q);
      uy2_q        <= DIFF_BITS'(ney_q) - DIFF_BITS'(nsy_q);
      dx2_q        <= DIFF_BITS'(oex_q) - DIFF_BITS'(osx_q);
      dy2_q        <= DIFF_BITS'(oey_q) - DIFF_BITS'(osy_q);
      ax2_q        <= DIFF_BITS'(osx_q) - DIFF_BITS'(nsx_q);
      ay2_q        <= DIFF_BITS'(osy_q) - DIFF_BITS'(nsy_q);
      ctx2_q.ux0   <= nex_q == nsx_q;
      ctx2_q.uy0   <= ney_q == nsy_q;
      ctx2_q.dx0   <= oex_q == osx_q;
      ctx2_q.none1 <= 1'b0;
      ctx2_q.none2 <= 1'b0;
      ctx2_q.sx    <= nsx_q;
      ctx2_q.sy    <= nsy_q;
      ctx2_q.ex    <= nex_q;
      ctx2_q.ey    <= ney_q;
      ctx2_q.px    <= osx_q;
      ctx2_q.py    <= osy_q;
      ctx2_q.lo    <= (osy_q < oey_q) ? osy_q : oey_q;
      ctx2_q.hi    <= (osy_q < oey_q) ? oey_q : osy_q;
    end
  end

  // stage 3: products of differences
  ctx_t  ctx3_q;
  diff_t ux3_q, uy3_q, dx3_q;
  prod_t uxdy3_q, uydx3_q, uydy3_q, uxdx3_q, axdy3_q, aydx3_q, uyax3_q, uxax3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx3_q  <= ctx2_q;
      ux3_q   <= ux2_q;
      uy3_q   <= uy2_q;
      dx3_q   <= dx2_q;
      uxdy3_q <= ux2_q * dy2_q;
      uydx3_q <= uy2_q * dx2_q;
      uydy3_q <= uy2_q * dy2_q;
      uxdx3_q <= ux2_q * dx2_q;
      axdy3_q <= ax2_q * dy2_q;
      aydx3_q <= ay2_q * dx2_q;
      uyax3_q <= uy2_q * ax2_q;
      uxax3_q <= ux2_q * ax2_q;
    end
  end

  // stage 4: cross products
  ctx_t  ctx4_q;
  diff_t ux4_q, uy4_q, dx4_q;
  wide_t den4_q, den24_q, num4_q;
  prod_t axdy4_q, uyax4_q, uxax4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx4_q  <= ctx3_q;
      ux4_q   <= ux3_q;
      uy4_q   <= uy3_q;
      dx4_q   <= dx3_q;
      den4_q  <= WIDE_BITS'(uxdy3_q) - WIDE_BITS'(uydx3_q);
      den24_q <= WIDE_BITS'(uydy3_q) + WIDE_BITS'(uxdx3_q);
      num4_q  <= WIDE_BITS'(axdy3_q) - WIDE_BITS'(aydx3_q);
      axdy4_q <= axdy3_q;
      uyax4_q <= uyax3_q;
      uxax4_q <= uxax3_q;
    end
  end

  // stage 5: split direction times cross product, no point flags
  ctx_t  ctx5_d, ctx5_q;
  diff_t ux5_q, uy5_q, dx5_q;
  wide_t den5_q, den25_q;
  prod_t axdy5_q, uyax5_q, uxax5_q;
  logic signed [DIFF_BITS+LO_BITS:0]  uxl5_q, uyl5_q;
  logic signed [DIFF_BITS+HI_BITS-1:0] uxh5_q, uyh5_q;
  logic signed [LO_BITS:0]   num_lo;
  logic signed [HI_BITS-1:0] num_hi;

  assign num_lo = $signed({1'b0, num4_q[LO_BITS-1:0]});
  assign num_hi = $signed(num4_q[WIDE_BITS-1:LO_BITS]);

  always_comb begin
    ctx5_d       = ctx4_q;
    ctx5_d.none1 = ctx4_q.ux0 ? ctx4_q.dx0 : (!ctx4_q.dx0 && den4_q == '0);
    ctx5_d.none2 = !ctx4_q.dx0 && den24_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx5_q  <= ctx5_d;
      ux5_q   <= ux4_q;
      uy5_q   <= uy4_q;
      dx5_q   <= dx4_q;
      den5_q  <= den4_q;
      den25_q <= den24_q;
      axdy5_q <= axdy4_q;
      uyax5_q <= uyax4_q;
      uxax5_q <= uxax4_q;
      uxl5_q  <= ux4_q * num_lo;
      uyl5_q  <= uy4_q * num_lo;
      uxh5_q  <= ux4_q * num_hi;
      uyh5_q  <= uy4_q * num_hi;
    end
  end

  // stage 6: join the partial products
  ctx_t  ctx6_q;
  diff_t ux6_q, uy6_q, dx6_q;
  wide_t den6_q, den26_q;
  prod_t axdy6_q, uyax6_q, uxax6_q;
  mul_t  uxn6_q, uyn6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx6_q  <= ctx5_q;
      ux6_q   <= ux5_q;
      uy6_q   <= uy5_q;
      dx6_q   <= dx5_q;
      den6_q  <= den5_q;
      den26_q <= den25_q;
      axdy6_q <= axdy5_q;
      uyax6_q <= uyax5_q;
      uxax6_q <= uxax5_q;
      uxn6_q  <= (MUL_BITS'(uxh5_q) <<< LO_BITS) + MUL_BITS'(uxl5_q);
      uyn6_q  <= (MUL_BITS'(uyh5_q) <<< LO_BITS) + MUL_BITS'(uyl5_q);
    end
  end

  // pick the division for each coordinate of both candidate points
  lane_t lx1, ly1, lx2, ly2;

  always_comb begin
    priority if (ctx6_q.ux0) begin
      lx1 = '{m: '0, neg: 1'b0, d: WIDE_BITS'(1), b: ctx6_q.sx};
      ly1 = '{m: MUL_BITS'(axdy6_q), neg: 1'b1, d: WIDE_BITS'(dx6_q), b: ctx6_q.py};
    end else if (ctx6_q.dx0) begin
      lx1 = '{m: '0, neg: 1'b0, d: WIDE_BITS'(1), b: ctx6_q.px};
      ly1 = '{m: MUL_BITS'(uyax6_q), neg: 1'b0, d: WIDE_BITS'(ux6_q), b: ctx6_q.sy};
    end else begin
      lx1 = '{m: uxn6_q, neg: 1'b0, d: den6_q, b: ctx6_q.sx};
      ly1 = '{m: uyn6_q, neg: 1'b0, d: den6_q, b: ctx6_q.sy};
    end
    // perpendicular through the new start point
    if (ctx6_q.dx0) begin
      lx2 = '{m: '0, neg: 1'b0, d: WIDE_BITS'(1), b: ctx6_q.px};
      ly2 = '{m: MUL_BITS'(uxax6_q), neg: 1'b1, d: WIDE_BITS'(uy6_q), b: ctx6_q.sy};
    end else begin
      lx2 = '{m: uyn6_q, neg: 1'b0, d: den26_q, b: ctx6_q.sx};
      ly2 = '{m: uxn6_q, neg: 1'b1, d: den26_q, b: ctx6_q.sy};
    end
  end

  div_res_t rx1, ry1, rx2, ry2;

  sbps_div u_div_x1 (.clk_i, .en_i(adv), .lane_i(lx1), .res_o(rx1));
  sbps_div u_div_y1 (.clk_i, .en_i(adv), .lane_i(ly1), .res_o(ry1));
  sbps_div u_div_x2 (.clk_i, .en_i(adv), .lane_i(lx2), .res_o(rx2));
  sbps_div u_div_y2 (.clk_i, .en_i(adv), .lane_i(ly2), .res_o(ry2));

  // context delay line beside the dividers
  ctx_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= ctx6_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  function automatic coord_t sat_f(div_res_t r);
    coord_t v;
    if (r.ovf) begin
      v = r.sgn ? COORD_MIN : COORD_MAX;
    end else if (r.val > RES_MAX) begin
      v = COORD_MAX;
    end else if (r.val < RES_MIN) begin
      v = COORD_MIN;
    end else begin
      v = r.val[COORD_BITS-1:0];
    end
    return v;
  endfunction

  // choose between direct point and fallback
  ctx_t     ctx_l;
  coord_t   x1, y1, x2, y2;
  logic     span1;
  coord_t   jx_d, jy_d, mx_d, my_d;
  outcome_e oc_d;

  always_comb begin
    ctx_l = side_q[DIV_LAT-1];
    x1    = sat_f(rx1);
    y1    = sat_f(ry1);
    x2    = sat_f(rx2);
    y2    = sat_f(ry2);
    span1 = !ry1.ovf && ry1.val >= RES_BITS'(ctx_l.lo) && ry1.val <= RES_BITS'(ctx_l.hi);
    priority if (!ctx_l.none1 && span1) begin
      jx_d = x1;
      jy_d = y1;
      oc_d = OUT_DIRECT;
    end else if (ctx_l.ux0) begin
      jx_d = ctx_l.px;
      jy_d = ctx_l.sy;
      oc_d = OUT_FALLBACK;
    end else if (ctx_l.uy0) begin
      jx_d = ctx_l.sx;
      jy_d = ctx_l.py;
      oc_d = OUT_FALLBACK;
    end else if (ctx_l.none2) begin
      jx_d = ctx_l.sx;
      jy_d = ctx_l.sy;
      oc_d = OUT_KEPT;
    end else begin
      jx_d = x2;
      jy_d = y2;
      oc_d = OUT_FALLBACK;
    end
    // keep a manhattan segment manhattan
    mx_d = ctx_l.ux0 ? jx_d : ctx_l.ex;
    my_d = (!ctx_l.ux0 && ctx_l.uy0) ? jy_d : ctx_l.ey;
  end

  // output register
  coord_t   joint_x_q, joint_y_q, moved_x_q, moved_y_q;
  outcome_e outcome_q;
  ctx_t     ctx_out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      joint_x_q <= jx_d;
      joint_y_q <= jy_d;
      moved_x_q <= mx_d;
      moved_y_q <= my_d;
      outcome_q <= oc_d;
      ctx_out_q <= ctx_l;
    end
  end

  assign out_valid_o   = vld_q[NSTG-1];
  assign joint_x_o     = FIELD_BITS'(joint_x_q);
  assign joint_y_o     = FIELD_BITS'(joint_y_q);
  assign moved_end_x_o = FIELD_BITS'(moved_x_q);
  assign moved_end_y_o = FIELD_BITS'(moved_y_q);
  assign outcome_o     = outcome_q;

  // a vertical new segment ends on the joint column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctx_out_q.ux0 |-> moved_x_q == joint_x_q)
    else $error("vertical segment end not moved to joint x");

  // a kept point is the new start of a sloped segment with no perpendicular
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_q == OUT_KEPT |->
      !ctx_out_q.ux0 && !ctx_out_q.uy0 && ctx_out_q.none2 &&
      joint_x_q == ctx_out_q.sx && joint_y_q == ctx_out_q.sy)
    else $error("kept point does not match new start");

  // a direct point lies within the existing segment's y span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_q == OUT_DIRECT |->
      joint_y_q >= ctx_out_q.lo && joint_y_q <= ctx_out_q.hi)
    else $error("direct point outside existing y span");

  // a stalled pipeline keeps its occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

endmodule

/* dv/segment_break_point_snap_tb.sv */
// segment_break_point_snap_tb: self-checking bench for the segment break point snap block
// depends on sbps_pkg and segment_break_point_snap; an internal predictor computes
// the expected joint points except for directed rows that carry known results

`timescale 1ns / 100ps

module segment_break_point_snap_tb;
  import sbps_pkg::*;

  localparam int NUM_RANDOM  = 880;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [159:0] big_t;

  typedef struct {
    coord_t sx, sy, ex, ey;
    coord_t px, py, qx, qy;
  } seg_pair_t;

  typedef struct {
    coord_t   jx, jy, mx, my;
    outcome_e oc;
  } snap_t;

  typedef struct {
    seg_pair_t p;
    bit        known;
    snap_t     r;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  coord_t   new_start_x_i = '0, new_start_y_i = '0, new_end_x_i = '0, new_end_y_i = '0;
  coord_t   old_start_x_i = '0, old_start_y_i = '0, old_end_x_i = '0, old_end_y_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  coord_t   joint_x_o, joint_y_o, moved_end_x_o, moved_end_y_o;
  outcome_e outcome_o;

  snap_t    pending_snaps[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       result_count = 0;
  int       send_idle_pct = 16;
  int       recv_stall_pct = 74;

  segment_break_point_snap dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // n / d rounded half away from zero
  function automatic big_t round_div(big_t n, big_t d);
    big_t mn, md, q, r;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = mn / md;
    r = mn - q * md;
    if (2 * r >= md) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(big_t v);
    if (v > big_t'(COORD_MAX)) return COORD_MAX;
    if (v < big_t'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // line through a with direction u against line p-q: 0 none, 1 outside span, 2 inside
  function automatic int line_meet(big_t ax, big_t ay, big_t ux, big_t uy,
                                   big_t px, big_t py, big_t qx, big_t qy,
                                   output coord_t jx, output coord_t jy);
    big_t dx, dy, xv, yv, den, num, lo, hi;
    dx = qx - px;
    dy = qy - py;
    jx = '0;
    jy = '0;
    if (ux == 0) begin
      if (dx == 0) return 0;
      xv = ax;
      yv = round_div(py * dx + dy * (ax - px), dx);
    end else if (dx == 0) begin
      xv = px;
      yv = round_div(ay * ux + uy * (px - ax), ux);
    end else begin
      den = ux * dy - uy * dx;
      if (den == 0) return 0;
      num = (px - ax) * dy - (py - ay) * dx;
      xv = round_div(ax * den + ux * num, den);
      yv = round_div(ay * den + uy * num, den);
    end
    lo = (py < qy) ? py : qy;
    hi = (py < qy) ? qy : py;
    jx = clamp_coord(xv);
    jy = clamp_coord(yv);
    return (yv >= lo && yv <= hi) ? 2 : 1;
  endfunction

  function automatic snap_t predict_snap(seg_pair_t p);
    snap_t s;
    big_t ux, uy;
    ux = big_t'(p.ex) - big_t'(p.sx);
    uy = big_t'(p.ey) - big_t'(p.sy);
    s.oc = OUT_DIRECT;
    if (line_meet(p.sx, p.sy, ux, uy, p.px, p.py, p.qx, p.qy, s.jx, s.jy) != 2) begin
      s.oc = OUT_FALLBACK;
      if (ux == 0) begin
        s.jx = p.px;
        s.jy = p.sy;
      end else if (uy == 0) begin
        s.jx = p.sx;
        s.jy = p.py;
      end else if (line_meet(p.sx, p.sy, uy, -ux, p.px, p.py, p.qx, p.qy,
                             s.jx, s.jy) == 0) begin
        s.jx = p.sx;
        s.jy = p.sy;
        s.oc = OUT_KEPT;
      end
    end
    s.mx = p.ex;
    s.my = p.ey;
    if (ux == 0) s.mx = s.jx;
    else if (uy == 0) s.my = s.jy;
    return s;
  endfunction

  function automatic coord_t near_coord(int span);
    return coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return near_coord(3);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly small crossing geometry, plus manhattan, parallel, degenerate and noise
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.sx = near_coord(1000); p.sy = near_coord(1000);
    p.ex = near_coord(1000); p.ey = near_coord(1000);
    p.px = near_coord(1000); p.py = near_coord(1000);
    p.qx = near_coord(1000); p.qy = near_coord(1000);
    case (kind)
      0, 1: begin
        p.sx = coord_t'($urandom); p.sy = coord_t'($urandom);
        p.ex = coord_t'($urandom); p.ey = coord_t'($urandom);
        p.px = coord_t'($urandom); p.py = coord_t'($urandom);
        p.qx = coord_t'($urandom); p.qy = coord_t'($urandom);
      end
      6: begin
        if ($urandom_range(0, 1)) p.ex = p.sx;
        else p.ey = p.sy;
      end
      7: begin
        p.px = p.sx + near_coord(50); p.py = p.sy + near_coord(50);
        p.qx = p.px + (p.ex - p.sx);  p.qy = p.py + (p.ey - p.sy);
      end
      8: begin
        p.ex = p.sx;
        p.ey = p.sy;
      end
      9: begin
        p.sx = edge_coord(); p.sy = edge_coord(); p.ex = edge_coord(); p.ey = edge_coord();
        p.px = edge_coord(); p.py = edge_coord(); p.qx = edge_coord(); p.qy = edge_coord();
      end
      default: begin
        // old segment spans the new line's neighborhood so direct hits are common
        p.qx = p.px + near_coord(400);
        p.qy = p.py + (($urandom_range(0, 1)) ? coord_t'(800) : coord_t'(-800));
      end
    endcase
    return p;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    snap_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count <= result_count + 1;
      if (pending_snaps.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_snaps.pop_front();
        if (joint_x_o !== want.jx) begin
          $error("joint_x expected %0d got %0d", want.jx, joint_x_o);
          fail_count++;
        end
        if (joint_y_o !== want.jy) begin
          $error("joint_y expected %0d got %0d", want.jy, joint_y_o);
          fail_count++;
        end
        if (moved_end_x_o !== want.mx) begin
          $error("moved_end_x expected %0d got %0d", want.mx, moved_end_x_o);
          fail_count++;
        end
        if (moved_end_y_o !== want.my) begin
          $error("moved_end_y expected %0d got %0d", want.my, moved_end_y_o);
          fail_count++;
        end
        if (outcome_o !== want.oc) begin
          $error("outcome expected %0d got %0d", want.oc, outcome_o);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int held;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && result_count >= 150) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // present one request and wait for its acceptance
  task automatic send_request(seg_pair_t p);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    new_start_x_i <= p.sx; new_start_y_i <= p.sy;
    new_end_x_i   <= p.ex; new_end_y_i   <= p.ey;
    old_start_x_i <= p.px; old_start_y_i <= p.py;
    old_end_x_i   <= p.qx; old_end_y_i   <= p.qy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stimulus
  initial begin
    row_t rows[14];
    snap_t s;
    int n;
    rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, OUT_FALLBACK}};
    rows[1]  = '{'{0, 5, 10, 5, 3, 0, 3, 10}, 1'b1, '{3, 5, 10, 5, OUT_DIRECT}};
    rows[2]  = '{'{2, 0, 2, 9, 0, 4, 8, 4}, 1'b1, '{2, 4, 2, 9, OUT_DIRECT}};
    rows[3]  = '{'{1, 0, 1, 5, 7, 0, 7, 5}, 1'b1, '{7, 0, 7, 5, OUT_FALLBACK}};
    rows[4]  = '{'{0, 0, 1, 1, 5, 0, 6, -1}, 1'b1, '{0, 0, 1, 1, OUT_KEPT}};
    rows[5]  = '{'{0, 0, 4, 4, 0, 2, 4, 6}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[6]  = '{'{0, 0, 4, 1, 10, 50, 12, 60}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[7]  = '{'{5, 5, 5, 5, 0, 0, 10, 10}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[8]  = '{'{0, 0, 2, 1, 1, -3, 1, 3}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[9]  = '{'{0, 0, -2, 1, -1, -3, -1, 3}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[10] = '{'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                   COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN}, 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[11] = '{'{COORD_MAX, 0, COORD_MAX, 1, COORD_MIN, -1, COORD_MIN + 1, 1},
                 1'b0, '{0, 0, 0, 0, OUT_DIRECT}};
    rows[12] = '{'{0, 0, 1, COORD_MAX, COORD_MIN, 0, COORD_MAX, 1}, 1'b0,
                 '{0, 0, 0, 0, OUT_DIRECT}};
    rows[13] = '{'{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0, 1, 0}, 1'b0,
                 '{0, 0, 0, 0, OUT_DIRECT}};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (rows[i]) begin
      s = rows[i].known ? rows[i].r : predict_snap(rows[i].p);
      send_request(rows[i].p);
      pending_snaps.push_back(s);
    end

    // random requests in three idling phases
    for (n = 0; n < NUM_RANDOM; n++) begin
      seg_pair_t p;
      if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 74;
        recv_stall_pct = 16;
      end
      if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (n == NUM_RANDOM / 2) begin
        // pause until the pipeline has drained
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_snaps.size() != 0);
      end
      p = random_pair();
      send_request(p);
      pending_snaps.push_back(predict_snap(p));
    end
    in_valid_i <= 1'b0;

    while (pending_snaps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
